// File: rtl/nbg_pkg.sv
// nbg_pkg: shared types, constants and helpers of the n-body gravity step.
// No dependencies; imported by every module of the block.
package nbg_pkg;

   localparam int FRAC_BITS = 16;
   localparam int GM_SHIFT  = 3 * FRAC_BITS - 24;   // Q8.24 * whole mass -> Q.3F
   localparam int CNT_W     = 7;                    // body counters, body_count width
   localparam int MAG_W     = 33;                   // |p_i - p_j|
   localparam int SQ_W      = 66;                   // squared distances
   localparam int GM_W      = 56;                   // G * m
   localparam int ACC_W     = 64;                   // saturated acceleration
   localparam int ROOT_W    = 33;                   // sqrt of the x-z squared distance
   localparam int DIV_NW    = ACC_W + MAG_W;        // widest dividend: a * |d|
   localparam int DIV_DW    = SQ_W;                 // widest divisor: r^2

   localparam logic [DIV_NW-1:0] COMP_CAP = DIV_NW'(64'h1_0000_0000);

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   localparam logic CSR_BODY_COUNT = 1'b0;
   localparam logic CSR_GRAV_CONST = 1'b1;

   localparam logic [CNT_W-1:0] BODY_COUNT_RST = 7'd64;
   localparam logic [31:0]      GRAV_CONST_RST = 32'd1119040;

   typedef enum logic [2:0] {
      MUL_XX  = 3'd0,
      MUL_ZZ  = 3'd1,
      MUL_YY  = 3'd2,
      MUL_GM  = 3'd3,
      MUL_CLO = 3'd4,
      MUL_CHI = 3'd5
   } mul_sel_type;

   typedef struct packed {
      logic              load_en;
      logic              ld_i;
      logic              ld_j;
      logic              coin_set;
      logic              mul_en;
      mul_sel_type       mul_sel;
      logic              div_start;
      logic              div_comp;
      logic              sqrt_start;
      logic              ld_a;
      logic              upd;
      logic              axis_z;
      logic              vwb;
      logic              emit;
      logic              last;
      logic [CNT_W-1:0]  rd_idx;
      logic [CNT_W-1:0]  wr_idx;
   } cmd_type;

   typedef struct packed {
      logic all_zero;
      logic xz_zero;
      logic div_busy;
      logic sqrt_busy;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647)
         r = 32'sh7FFF_FFFF;
      else if (v < -34'sd2147483648)
         r = 32'sh8000_0000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

// File: rtl/nbg_div.sv
// nbg_div: restoring divider, one quotient bit per cycle.
// Depends on nbg_pkg for widths.
module nbg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nbg_pkg::DIV_NW-1:0] dividend,
   input  logic [nbg_pkg::DIV_DW-1:0] divisor,
   output logic                       busy,
   output logic [nbg_pkg::DIV_NW-1:0] quot
);
   import nbg_pkg::*;

   localparam int CW = $clog2(DIV_NW + 1);

   logic [DIV_DW:0]   rem_ff, rem_in;
   logic [DIV_NW-1:0] quot_ff, quot_in;
   logic [DIV_DW-1:0] dsor_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_DW:0]   rem_sh;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff[DIV_DW-1:0], quot_ff[DIV_NW-1]};
      ge      = rem_sh >= {1'b0, dsor_ff};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (rem_sh - {1'b0, dsor_ff}) : rem_sh;
         quot_in = {quot_ff[DIV_NW-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DIV_NW - 1))
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (start)
         dsor_ff <= divisor;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

// File: rtl/nbg_sqrt.sv
// nbg_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on nbg_pkg for widths.
module nbg_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [nbg_pkg::SQ_W-1:0]   rad,
   output logic                       busy,
   output logic [nbg_pkg::ROOT_W-1:0] root
);
   import nbg_pkg::*;

   localparam int RW = ROOT_W + 2;
   localparam int CW = $clog2(ROOT_W + 1);

   logic [SQ_W-1:0]   rad_ff, rad_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [RW+1:0]     rem_sh, trial;
   logic              ge;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[SQ_W-1:SQ_W-2]};
      trial   = (RW+2)'({root_ff, 2'b01});
      ge      = rem_sh >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[SQ_W-3:0], 2'b00};
         rem_in  = ge ? RW'(rem_sh - trial) : RW'(rem_sh);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CW'(ROOT_W - 1))
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// File: rtl/nbg_ctrl.sv
// nbg_ctrl: sequencer for loads, the pair loop, velocity write-back and the output run.
// Depends on nbg_pkg (cmd_type, sts_type, codes).
module nbg_ctrl #(
   parameter int MAX_BODIES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_func,
   input  logic [nbg_pkg::CNT_W-1:0] body_count,
   input  nbg_pkg::sts_type          sts,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output nbg_pkg::cmd_type          cmd
);
   import nbg_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_IRD     = 14'b00000000000010,
      S_ILAT    = 14'b00000000000100,
      S_JRD     = 14'b00000000001000,
      S_JLAT    = 14'b00000000010000,
      S_CHK     = 14'b00000000100000,
      S_MUL     = 14'b00000001000000,
      S_LAUNCH  = 14'b00000010000000,
      S_ROOT    = 14'b00000100000000,
      S_CPROD   = 14'b00001000000000,
      S_CLAUNCH = 14'b00010000000000,
      S_CDIV    = 14'b00100000000000,
      S_VWB     = 14'b01000000000000,
      S_EOUT    = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in, n_ff, n_in, n_cap;
   logic [1:0]       mstep_ff, mstep_in;
   logic             pstep_ff, pstep_in;
   logic             axis_ff, axis_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             i_last, out_free;

   assign n_cap    = (int'(body_count) > MAX_BODIES) ? CNT_W'(MAX_BODIES) : body_count;
   assign i_last   = (i_ff == n_ff - 1'b1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      mstep_in     = mstep_ff;
      pstep_in     = pstep_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_XX;
      cmd.rd_idx   = i_ff;
      cmd.wr_idx   = i_ff;
      cmd.axis_z   = axis_ff;
      cmd.last     = i_last;
      req_ready    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_func == FUNC_LOAD) begin
                  cmd.load_en = 1'b1;
               end else if (n_cap != '0) begin
                  n_in     = n_cap;
                  i_in     = '0;
                  state_in = S_IRD;
               end
            end
         end
         S_IRD: state_in = S_ILAT;
         S_ILAT: begin
            cmd.ld_i = 1'b1;
            j_in     = '0;
            state_in = S_JRD;
         end
         S_JRD: begin
            cmd.rd_idx = j_ff;
            if (j_ff == n_ff)
               state_in = S_VWB;
            else if (j_ff == i_ff)
               j_in = j_ff + 1'b1;
            else
               state_in = S_JLAT;
         end
         S_JLAT: begin
            cmd.ld_j = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (sts.all_zero) begin
               cmd.coin_set = 1'b1;
               j_in         = j_ff + 1'b1;
               state_in     = S_JRD;
            end else if (sts.xz_zero) begin
               j_in     = j_ff + 1'b1;
               state_in = S_JRD;
            end else begin
               mstep_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            case (mstep_ff)
               2'd0:    cmd.mul_sel = MUL_XX;
               2'd1:    cmd.mul_sel = MUL_ZZ;
               2'd2:    cmd.mul_sel = MUL_YY;
               default: cmd.mul_sel = MUL_GM;
            endcase
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 2'd3)
               state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            cmd.div_start  = 1'b1;
            cmd.sqrt_start = 1'b1;
            state_in       = S_ROOT;
         end
         S_ROOT: begin
            if (!sts.div_busy && !sts.sqrt_busy) begin
               cmd.ld_a = 1'b1;
               axis_in  = 1'b0;
               pstep_in = 1'b0;
               state_in = S_CPROD;
            end
         end
         S_CPROD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pstep_ff ? MUL_CHI : MUL_CLO;
            pstep_in    = !pstep_ff;
            if (pstep_ff)
               state_in = S_CLAUNCH;
         end
         S_CLAUNCH: begin
            cmd.div_start = 1'b1;
            cmd.div_comp  = 1'b1;
            state_in      = S_CDIV;
         end
         S_CDIV: begin
            if (!sts.div_busy) begin
               cmd.upd = 1'b1;
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  pstep_in = 1'b0;
                  state_in = S_CPROD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = S_JRD;
               end
            end
         end
         S_VWB: begin
            cmd.vwb = 1'b1;
            if (i_last) begin
               i_in     = '0;
               mstep_in = 2'd1;   // body 0 read data not there yet
               state_in = S_EOUT;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = S_IRD;
            end
         end
         S_EOUT: begin
            // read data for body i lands in the cycle after the address changes
            if (out_free && !mstep_ff[0]) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               mstep_in     = 2'd1;
               if (i_last)
                  state_in = S_IDLE;
               else
                  i_in = i_ff + 1'b1;
            end else begin
               mstep_in = 2'd0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         mstep_ff     <= '0;
         pstep_ff     <= 1'b0;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         mstep_ff     <= mstep_in;
         pstep_ff     <= pstep_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: rtl/nbg_dp.sv
// nbg_dp: body stores, pair arithmetic, shared multiplier, divider, root unit, output regs.
// Depends on nbg_pkg, nbg_div and nbg_sqrt.
module nbg_dp #(
   parameter int MAX_BODIES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  nbg_pkg::cmd_type          cmd,
   output nbg_pkg::sts_type          sts,
   input  logic [31:0]               grav_const,
   input  logic [5:0]                req_body_index,
   input  logic signed [31:0]        req_pos_x,
   input  logic signed [31:0]        req_pos_y,
   input  logic signed [31:0]        req_pos_z,
   input  logic signed [31:0]        req_vel_x,
   input  logic signed [31:0]        req_vel_y,
   input  logic signed [31:0]        req_vel_z,
   input  logic [23:0]               req_body_mass,
   output logic [5:0]                rsp_out_index,
   output logic signed [31:0]        rsp_new_x,
   output logic signed [31:0]        rsp_new_y,
   output logic signed [31:0]        rsp_new_z,
   output logic signed [31:0]        rsp_new_vx,
   output logic signed [31:0]        rsp_new_vy,
   output logic signed [31:0]        rsp_new_vz,
   output logic                      rsp_coincident,
   output logic                      rsp_last
);
   import nbg_pkg::*;

   localparam int AW = $clog2(MAX_BODIES);

   // body stores
   logic signed [31:0] pos_x_mem [MAX_BODIES];
   logic signed [31:0] pos_y_mem [MAX_BODIES];
   logic signed [31:0] pos_z_mem [MAX_BODIES];
   logic signed [31:0] vel_x_mem [MAX_BODIES];
   logic signed [31:0] vel_y_mem [MAX_BODIES];
   logic signed [31:0] vel_z_mem [MAX_BODIES];
   logic [23:0]        mass_mem  [MAX_BODIES];
   logic               coin_mem  [MAX_BODIES];

   logic signed [31:0] rd_px_ff, rd_py_ff, rd_pz_ff, rd_vx_ff, rd_vy_ff, rd_vz_ff;
   logic [23:0]        rd_m_ff;
   logic               rd_c_ff;

   logic               load_ok, pos_we, vxz_we;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] pos_wx, pos_wy, pos_wz, vel_wx, vel_wz;
   logic signed [31:0] np_x, np_y, np_z;

   // body i and pair registers
   logic signed [31:0] pix_ff, piy_ff, piz_ff, vx_ff, vz_ff;
   logic               coin_ff;
   logic [MAG_W-1:0]   ux_ff, uy_ff, uz_ff;
   logic               sx_ff, sz_ff, all_zero_ff, xz_zero_ff;
   logic [23:0]        mj_ff;
   logic signed [32:0] dx, dy, dz;

   // arithmetic registers
   logic [SQ_W-1:0]    rho2_ff, r2_ff;
   logic [GM_W-1:0]    gm_ff;
   logic [DIV_NW-1:0]  cp_ff;
   logic [ACC_W-1:0]   a_ff;
   logic [MAG_W-1:0]   mul_a, mul_b, ud;
   logic [SQ_W-1:0]    prod;

   logic [DIV_NW-1:0]  div_n, quot;
   logic [DIV_DW-1:0]  div_d;
   logic               div_busy, sqrt_busy;
   logic [ROOT_W-1:0]  root;

   logic [MAG_W-1:0]   cv;
   logic signed [33:0] vext, vnew;
   logic signed [31:0] vsel;
   logic               vsign;

   logic [5:0]         out_index_ff;
   logic signed [31:0] nx_ff, ny_ff, nz_ff, nvx_ff, nvy_ff, nvz_ff;
   logic               ncoin_ff, nlast_ff;

   assign load_ok = int'(req_body_index) < MAX_BODIES;
   assign rd_addr = AW'(cmd.rd_idx);
   assign wr_addr = cmd.load_en ? AW'(req_body_index) : AW'(cmd.wr_idx);

   // new positions for the output run
   assign np_x = sat32(34'(rd_px_ff) + 34'(rd_vx_ff));
   assign np_y = sat32(34'(rd_py_ff) + 34'(rd_vy_ff));
   assign np_z = sat32(34'(rd_pz_ff) + 34'(rd_vz_ff));

   assign pos_we = (cmd.load_en && load_ok) || cmd.emit;
   assign vxz_we = (cmd.load_en && load_ok) || cmd.vwb;
   assign pos_wx = cmd.load_en ? req_pos_x : np_x;
   assign pos_wy = cmd.load_en ? req_pos_y : np_y;
   assign pos_wz = cmd.load_en ? req_pos_z : np_z;
   assign vel_wx = cmd.load_en ? req_vel_x : vx_ff;
   assign vel_wz = cmd.load_en ? req_vel_z : vz_ff;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_x_mem[wr_addr] <= pos_wx;
         pos_y_mem[wr_addr] <= pos_wy;
         pos_z_mem[wr_addr] <= pos_wz;
      end
      if (vxz_we) begin
         vel_x_mem[wr_addr] <= vel_wx;
         vel_z_mem[wr_addr] <= vel_wz;
      end
      if (cmd.load_en && load_ok) begin
         vel_y_mem[wr_addr] <= req_vel_y;
         mass_mem[wr_addr]  <= req_body_mass;
      end
      if (cmd.vwb)
         coin_mem[wr_addr] <= coin_ff;
      rd_px_ff <= pos_x_mem[rd_addr];
      rd_py_ff <= pos_y_mem[rd_addr];
      rd_pz_ff <= pos_z_mem[rd_addr];
      rd_vx_ff <= vel_x_mem[rd_addr];
      rd_vy_ff <= vel_y_mem[rd_addr];
      rd_vz_ff <= vel_z_mem[rd_addr];
      rd_m_ff  <= mass_mem[rd_addr];
      rd_c_ff  <= coin_mem[rd_addr];
   end

   // separation of body i from partner j
   assign dx = 33'(pix_ff) - 33'(rd_px_ff);
   assign dy = 33'(piy_ff) - 33'(rd_py_ff);
   assign dz = 33'(piz_ff) - 33'(rd_pz_ff);

   // shared multiplier
   assign ud = cmd.axis_z ? uz_ff : ux_ff;
   always_comb begin
      case (cmd.mul_sel)
         MUL_XX:  begin mul_a = ux_ff;                 mul_b = ux_ff; end
         MUL_ZZ:  begin mul_a = uz_ff;                 mul_b = uz_ff; end
         MUL_YY:  begin mul_a = uy_ff;                 mul_b = uy_ff; end
         MUL_GM:  begin mul_a = MAG_W'(grav_const);    mul_b = MAG_W'(mj_ff); end
         MUL_CLO: begin mul_a = MAG_W'(a_ff[31:0]);    mul_b = ud; end
         MUL_CHI: begin mul_a = MAG_W'(a_ff[63:32]);   mul_b = ud; end
         default: begin mul_a = '0;                    mul_b = '0; end
      endcase
   end
   assign prod = SQ_W'(mul_a) * SQ_W'(mul_b);

   // divider: accel = (G*m << shift) / r^2, component = a*|d| / rho
   assign div_n = cmd.div_comp ? cp_ff : (DIV_NW'(gm_ff) << GM_SHIFT);
   assign div_d = cmd.div_comp ? DIV_DW'(root) : r2_ff;

   nbg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .busy     (div_busy),
      .quot     (quot)
   );

   nbg_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .rad   (rho2_ff),
      .busy  (sqrt_busy),
      .root  (root)
   );

   // velocity component update, pull toward partner
   assign cv    = (quot > COMP_CAP) ? MAG_W'(COMP_CAP) : quot[MAG_W-1:0];
   assign vsel  = cmd.axis_z ? vz_ff : vx_ff;
   assign vsign = cmd.axis_z ? sz_ff : sx_ff;
   assign vext  = 34'(vsel);
   assign vnew  = vsign ? (vext - signed'(34'(cv))) : (vext + signed'(34'(cv)));

   always_ff @(posedge clock) begin
      if (cmd.ld_i) begin
         pix_ff  <= rd_px_ff;
         piy_ff  <= rd_py_ff;
         piz_ff  <= rd_pz_ff;
         vx_ff   <= rd_vx_ff;
         vz_ff   <= rd_vz_ff;
         coin_ff <= 1'b0;
      end else if (cmd.coin_set) begin
         coin_ff <= 1'b1;
      end else if (cmd.upd) begin
         if (cmd.axis_z)
            vz_ff <= sat32(vnew);
         else
            vx_ff <= sat32(vnew);
      end
      if (cmd.ld_j) begin
         ux_ff       <= dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
         uy_ff       <= dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
         uz_ff       <= dz[32] ? MAG_W'(-dz) : MAG_W'(dz);
         sx_ff       <= (dx > 33'sd0);
         sz_ff       <= (dz > 33'sd0);
         xz_zero_ff  <= (dx == '0) && (dz == '0);
         all_zero_ff <= (dx == '0) && (dy == '0) && (dz == '0);
         mj_ff       <= rd_m_ff;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_XX:  rho2_ff <= prod;
            MUL_ZZ:  rho2_ff <= rho2_ff + prod;
            MUL_YY:  r2_ff   <= rho2_ff + prod;
            MUL_GM:  gm_ff   <= prod[GM_W-1:0];
            MUL_CLO: cp_ff   <= DIV_NW'(prod);
            MUL_CHI: cp_ff   <= cp_ff + (DIV_NW'(prod) << 32);
            default: cp_ff   <= cp_ff;
         endcase
      end
      if (cmd.ld_a)
         a_ff <= (|quot[DIV_NW-1:ACC_W]) ? '1 : quot[ACC_W-1:0];
      if (cmd.emit) begin
         out_index_ff <= cmd.wr_idx[5:0];
         nx_ff        <= np_x;
         ny_ff        <= np_y;
         nz_ff        <= np_z;
         nvx_ff       <= rd_vx_ff;
         nvy_ff       <= rd_vy_ff;
         nvz_ff       <= rd_vz_ff;
         ncoin_ff     <= rd_c_ff;
         nlast_ff     <= cmd.last;
      end
   end

   assign sts.all_zero  = all_zero_ff;
   assign sts.xz_zero   = xz_zero_ff;
   assign sts.div_busy  = div_busy;
   assign sts.sqrt_busy = sqrt_busy;

   assign rsp_out_index  = out_index_ff;
   assign rsp_new_x      = nx_ff;
   assign rsp_new_y      = ny_ff;
   assign rsp_new_z      = nz_ff;
   assign rsp_new_vx     = nvx_ff;
   assign rsp_new_vy     = nvy_ff;
   assign rsp_new_vz     = nvz_ff;
   assign rsp_coincident = ncoin_ff;
   assign rsp_last       = nlast_ff;

endmodule

// File: rtl/nbody_gravity_step.sv
// nbody_gravity_step: top level, configuration registers, controller and datapath.
// Depends on nbg_pkg, nbg_ctrl and nbg_dp.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  req     | in        | req_valid/req_ready  | func, body index, position, velocity, mass
//  rsp     | out       | rsp_valid/rsp_ready  | index, new position/velocity, coincident, last
//  csr     | in        | csr_valid/csr_ready  | register index, write data
//
// A load request writes one body into the stores.
// A step request runs every ordered pair (i, j), i != j; the work per pair is set by
// the one-bit-per-cycle divider (accel, x share, z share); skipped pairs do not divide.
// Each result is held in an output register; a stalled rsp side halts the output run.
// Reset is synchronous; the body stores are not cleared and read as garbage until loaded.
// csr writes are always accepted; write only while no step is in flight.
module nbody_gravity_step #(
   parameter int MAX_BODIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [5:0]         req_body_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [23:0]        req_body_mass,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_out_index,
   output logic signed [31:0] rsp_new_x,
   output logic signed [31:0] rsp_new_y,
   output logic signed [31:0] rsp_new_z,
   output logic signed [31:0] rsp_new_vx,
   output logic signed [31:0] rsp_new_vy,
   output logic signed [31:0] rsp_new_vz,
   output logic               rsp_coincident,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_data
);
   import nbg_pkg::*;

   logic [CNT_W-1:0] body_count_ff;
   logic [31:0]      grav_const_ff;
   cmd_type          cmd;
   sts_type          sts;

   // configuration registers, written any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_count_ff <= BODY_COUNT_RST;
         grav_const_ff <= GRAV_CONST_RST;
      end else if (csr_valid) begin
         if (csr_index == CSR_BODY_COUNT)
            body_count_ff <= csr_data[CNT_W-1:0];
         else
            grav_const_ff <= csr_data;
      end
   end

   nbg_ctrl #(.MAX_BODIES(MAX_BODIES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .body_count (body_count_ff),
      .sts        (sts),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   nbg_dp #(.MAX_BODIES(MAX_BODIES)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .grav_const     (grav_const_ff),
      .req_body_index (req_body_index),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_vel_x      (req_vel_x),
      .req_vel_y      (req_vel_y),
      .req_vel_z      (req_vel_z),
      .req_body_mass  (req_body_mass),
      .rsp_out_index  (rsp_out_index),
      .rsp_new_x      (rsp_new_x),
      .rsp_new_y      (rsp_new_y),
      .rsp_new_z      (rsp_new_z),
      .rsp_new_vx     (rsp_new_vx),
      .rsp_new_vy     (rsp_new_vy),
      .rsp_new_vz     (rsp_new_vz),
      .rsp_coincident (rsp_coincident),
      .rsp_last       (rsp_last)
   );

endmodule

// File: dv/nbg_checker.sv
// nbg_checker: watches the request, response and csr channels of nbody_gravity_step,
// predicts every body report of a step and compares. Depends on nbg_pkg.
module nbg_checker
   import nbg_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_func,
   input  logic [5:0]         req_body_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [23:0]        req_body_mass,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [5:0]         rsp_out_index,
   input  logic signed [31:0] rsp_new_x,
   input  logic signed [31:0] rsp_new_y,
   input  logic signed [31:0] rsp_new_z,
   input  logic signed [31:0] rsp_new_vx,
   input  logic signed [31:0] rsp_new_vy,
   input  logic signed [31:0] rsp_new_vz,
   input  logic               rsp_coincident,
   input  logic               rsp_last,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_data,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [5:0]         idx;
      logic signed [31:0] x, y, z, vx, vy, vz;
      logic               coin, last;
   } body_report_type;

   body_report_type report_q[$];
   longint          body_pos[64][3];
   longint          body_vel[64][3];
   logic [23:0]     body_mass[64];
   logic [6:0]      count_reg;
   logic [31:0]     grav_reg;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [33:0] root_floor(logic [67:0] v);
      logic [33:0] r;
      logic [33:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (34'd1 << b);
         if ({34'd0, c} * {34'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   // velocity nudged by a*|d|/rho toward the partner, component capped at 2^32
   function automatic longint pulled(longint v, longint d, logic [63:0] a, logic [33:0] rho);
      logic [127:0] c;
      logic [127:0] m;
      longint       cv;
      m = (d < 0) ? 128'(-d) : 128'(d);
      c = ({64'd0, a} * m) / {94'd0, rho};
      cv = (c > 128'h1_0000_0000) ? 64'sh1_0000_0000 : longint'(c[32:0]);
      if (d > 0) return clip32(v - cv);
      if (d < 0) return clip32(v + cv);
      return v;
   endfunction

   task automatic predict_step();
      int              n;
      longint          vx, vz, dx, dy, dz;
      logic [127:0]    ux, uy, uz, rho2, r2, num, q;
      logic [63:0]     a;
      logic            coin[64];
      body_report_type rep;
      n = (count_reg > 7'd64) ? 64 : int'(count_reg);
      for (int i = 0; i < n; i++) begin
         vx = body_vel[i][0];
         vz = body_vel[i][2];
         coin[i] = 1'b0;
         for (int j = 0; j < n; j++) begin
            if (j == i) continue;
            dx = body_pos[i][0] - body_pos[j][0];
            dy = body_pos[i][1] - body_pos[j][1];
            dz = body_pos[i][2] - body_pos[j][2];
            if (dx == 0 && dy == 0 && dz == 0) begin
               coin[i] = 1'b1;
               continue;
            end
            if (dx == 0 && dz == 0) continue;   // straight above/below: no x-z pull
            ux = (dx < 0) ? 128'(-dx) : 128'(dx);
            uy = (dy < 0) ? 128'(-dy) : 128'(dy);
            uz = (dz < 0) ? 128'(-dz) : 128'(dz);
            rho2 = ux * ux + uz * uz;
            r2 = rho2 + uy * uy;
            num = ({96'd0, grav_reg} * {104'd0, body_mass[j]}) << GM_SHIFT;
            q = num / r2;
            a = (q[127:64] != 0) ? '1 : q[63:0];
            vx = pulled(vx, dx, a, root_floor(rho2[67:0]));
            vz = pulled(vz, dz, a, root_floor(rho2[67:0]));
         end
         body_vel[i][0] = vx;
         body_vel[i][2] = vz;
      end
      for (int i = 0; i < n; i++) begin
         for (int k = 0; k < 3; k++)
            body_pos[i][k] = clip32(body_pos[i][k] + body_vel[i][k]);
         rep.idx  = 6'(i);
         rep.x    = body_pos[i][0][31:0];
         rep.y    = body_pos[i][1][31:0];
         rep.z    = body_pos[i][2][31:0];
         rep.vx   = body_vel[i][0][31:0];
         rep.vy   = body_vel[i][1][31:0];
         rep.vz   = body_vel[i][2][31:0];
         rep.coin = coin[i];
         rep.last = (i + 1 == n);
         report_q.push_back(rep);
      end
   endtask

   task automatic check_field(string name, longint exp, longint act);
      if (exp != act) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
      end
   endtask

   always @(posedge clock) begin
      body_report_type e;
      if (reset) begin
         count_reg = BODY_COUNT_RST;
         grav_reg  = GRAV_CONST_RST;
         report_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BODY_COUNT) count_reg = csr_data[6:0];
            else grav_reg = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (report_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, index %0d", $time, rsp_out_index);
            end else begin
               e = report_q.pop_front();
               check_field("out_index", e.idx, rsp_out_index);
               check_field("new_x", e.x, rsp_new_x);
               check_field("new_y", e.y, rsp_new_y);
               check_field("new_z", e.z, rsp_new_z);
               check_field("new_vx", e.vx, rsp_new_vx);
               check_field("new_vy", e.vy, rsp_new_vy);
               check_field("new_vz", e.vz, rsp_new_vz);
               check_field("coincident", e.coin, rsp_coincident);
               check_field("last", e.last, rsp_last);
            end
         end
         if (req_valid && req_ready) begin
            if (req_func == FUNC_LOAD) begin
               body_pos[req_body_index][0] = req_pos_x;
               body_pos[req_body_index][1] = req_pos_y;
               body_pos[req_body_index][2] = req_pos_z;
               body_vel[req_body_index][0] = req_vel_x;
               body_vel[req_body_index][1] = req_vel_y;
               body_vel[req_body_index][2] = req_vel_z;
               body_mass[req_body_index]   = req_body_mass;
            end else begin
               predict_step();
            end
         end
      end
      pending = report_q.size();
   end

endmodule

// File: dv/tb.sv
// tb: stimulus and verdict for nbody_gravity_step.
// Depends on nbg_pkg, the RTL and dv/nbg_checker.sv.
module tb;
   import nbg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 10_000_000;

   logic               clock;
   logic               reset;
   logic               req_valid, req_ready, req_func;
   logic [5:0]         req_body_index;
   logic signed [31:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [31:0] req_vel_x, req_vel_y, req_vel_z;
   logic [23:0]        req_body_mass;
   logic               rsp_valid, rsp_ready;
   logic [5:0]         rsp_out_index;
   logic signed [31:0] rsp_new_x, rsp_new_y, rsp_new_z;
   logic signed [31:0] rsp_new_vx, rsp_new_vy, rsp_new_vz;
   logic               rsp_coincident, rsp_last;
   logic               csr_valid, csr_ready, csr_index;
   logic [31:0]        csr_data;

   int                 errors, pending;
   int                 cycles = 0;
   int                 rsp_stall = 0;
   int                 items = 0;
   bit                 quiet = 0;        // no idling on either side near the end
   bit                 loaded[64];       // a step must never read a body never loaded
   int                 body_limit = 64;  // bodies a step reads under the current count

   nbody_gravity_step DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_body_index(req_body_index),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_vel_x(req_vel_x), .req_vel_y(req_vel_y), .req_vel_z(req_vel_z),
      .req_body_mass(req_body_mass),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_index(rsp_out_index),
      .rsp_new_x(rsp_new_x), .rsp_new_y(rsp_new_y), .rsp_new_z(rsp_new_z),
      .rsp_new_vx(rsp_new_vx), .rsp_new_vy(rsp_new_vy), .rsp_new_vz(rsp_new_vz),
      .rsp_coincident(rsp_coincident), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   nbg_checker u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // watchdog: a hung step or a lost response ends the run here
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // response side: random stalls, none while quiet
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_ready = 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready = 1'b0;
         rsp_stall = $urandom_range(0, 2);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // drop valid, drain every expected report, then let a trailing load settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] data);
      wait_idle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == CSR_BODY_COUNT) body_limit = (data[6:0] > 7'd64) ? 64 : int'(data[6:0]);
   endtask

   task automatic send_request(logic f, logic [5:0] idx, logic signed [31:0] px,
                               logic signed [31:0] py, logic signed [31:0] pz,
                               logic signed [31:0] vx, logic signed [31:0] vy,
                               logic signed [31:0] vz, logic [23:0] m);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_func       = f;
      req_body_index = idx;
      req_pos_x = px;  req_pos_y = py;  req_pos_z = pz;
      req_vel_x = vx;  req_vel_y = vy;  req_vel_z = vz;
      req_body_mass  = m;
      do @(posedge clock); while (!req_ready);
      items++;
   endtask

   task automatic load_body(logic [5:0] idx, logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic signed [31:0] vx,
                            logic signed [31:0] vy, logic signed [31:0] vz, logic [23:0] m);
      loaded[idx] = 1'b1;
      send_request(FUNC_LOAD, idx, px, py, pz, vx, vy, vz, m);
   endtask

   // mostly a few units apart so the pull is visible; sometimes full range or on a
   // coarse grid so coincident and vertical pairs turn up
   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 7))
         0:       return $urandom;
         1:       return 32'sd65536 * $signed(32'($urandom_range(0, 2)));
         default: return $signed(32'($urandom_range(0, 32'h3F_FFFF))) - 32'sh20_0000;
      endcase
   endfunction

   function automatic logic signed [31:0] rand_speed();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $signed(32'($urandom_range(0, 32'h3FFF))) - 32'sh2000;
   endfunction

   task automatic load_random(logic [5:0] idx);
      load_body(idx, rand_coord(), rand_coord(), rand_coord(), rand_speed(), rand_speed(),
                rand_speed(),
                ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000)));
   endtask

   // step request; payload is don't-care, so it is randomized
   task automatic run_step();
      for (int i = 0; i < body_limit; i++)
         if (!loaded[i]) load_random(6'(i));
      send_request(FUNC_STEP, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, 24'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;  req_func = FUNC_LOAD;  req_body_index = '0;
      req_pos_x = '0;  req_pos_y = '0;  req_pos_z = '0;
      req_vel_x = '0;  req_vel_y = '0;  req_vel_z = '0;
      req_body_mass = '0;
      csr_valid = 1'b0;  csr_index = CSR_BODY_COUNT;  csr_data = '0;
      rsp_ready = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty step, lone body, coincident pair, vertical pair,
      // massless partner, saturating extremes, G at both ends
      csr_write(CSR_BODY_COUNT, 32'd64);
      csr_write(CSR_BODY_COUNT, 32'd0);
      run_step();
      load_body(6'd0, 0, 0, 0, 32'sh7FFF_FFFF, 5, 32'sh8000_0000, 24'd1000);
      load_body(6'd1, 32'sd196608, 0, -32'sd262144, 0, 0, 0, 24'hFF_FFFF);
      load_body(6'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, -1, -1, 24'd0);
      load_body(6'd3, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 7, 0, -7, 24'd50);
      load_body(6'd4, 0, 32'sd458752, 0, 0, 32'sh8000_0000, 0, 24'd200);
      load_body(6'd5, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 24'hFF_FFFF);
      load_body(6'd63, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 24'hFF_FFFF);
      csr_write(CSR_BODY_COUNT, 32'd1);
      run_step();
      csr_write(CSR_BODY_COUNT, 32'd2);
      run_step();
      csr_write(CSR_BODY_COUNT, 32'd6);
      run_step();
      csr_write(CSR_GRAV_CONST, 32'hFFFF_FFFF);
      run_step();
      csr_write(CSR_GRAV_CONST, 32'd0);
      run_step();
      csr_write(CSR_GRAV_CONST, GRAV_CONST_RST);
      run_step();

      // random: mostly loads into the low bodies with steps mixed in; occasional
      // reconfiguration, which also holds the sender until the block drains
      while (items < 100) begin
         if (items >= 80) quiet = 1;
         if ($urandom_range(0, 9) < 3) begin
            if ($urandom_range(0, 2) == 0) begin
               csr_write(CSR_BODY_COUNT, ($urandom_range(0, 9) == 0) ? 32'd0
                                                                     : $urandom_range(1, 8));
               case ($urandom_range(0, 3))
                  0:       csr_write(CSR_GRAV_CONST, $urandom);
                  default: csr_write(CSR_GRAV_CONST, $urandom_range(0, 32'h40_0000));
               endcase
            end
            run_step();
         end else begin
            load_random(($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)));
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (errors == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
